@@ rtl/core/rese_pkg.sv @@
// Shared types and constants for the row exchange sorter.
`timescale 1ns / 1ps
`default_nettype none

package rese_pkg;

    localparam int VAL_W      = 16;
    localparam int TALLY_W    = 16;
    localparam int SIZE_W     = 5;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [TALLY_W-1:0] TALLY_MAX  = 16'hFFFF;
    localparam logic [SIZE_W-1:0]  SIZE_RESET = 5'd16;

    // Register index, taken from the word address
    localparam logic REG_MATRIX_SIZE = 1'b0;

    // One element on its way from the front to the back, with its position flags
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    row_last;
        logic                    matrix_last;
    } row_item_t;

endpackage

`default_nettype wire

@@ rtl/core/rese_front.sv @@
// Front end: accept elements, tag row and matrix boundaries, push to the queue.
`timescale 1ns / 1ps
`default_nettype none

module rese_front
    import rese_pkg::*;
#(
    parameter int MAX_SIZE = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           clear,
    input  wire logic [$clog2(MAX_SIZE+1)-1:0]  size_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [VAL_W-1:0]        element_value,
    output logic                                q_push,
    output row_item_t                           q_item,
    input  wire logic                           q_ready
);

    localparam int CNT_W = $clog2(MAX_SIZE + 1);
    localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

    logic [IDX_W-1:0] col_reg, col_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic             col_last;
    logic             row_last;

    assign in_ready = q_ready;
    assign q_push   = in_valid && q_ready;

    assign col_last = (CNT_W'(col_reg) + CNT_W'(1)) == size_n;
    assign row_last = (CNT_W'(row_reg) + CNT_W'(1)) == size_n;

    always_comb
    begin
        q_item.value       = element_value;
        q_item.row_last    = col_last;
        q_item.matrix_last = col_last && row_last;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (clear)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (q_push)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? '0 : IDX_W'(row_reg + IDX_W'(1));
            end
            else
            begin
                col_next = IDX_W'(col_reg + IDX_W'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/rese_fifo.sv @@
// Two-entry queue between the front end and the sort engine.
`timescale 1ns / 1ps
`default_nettype none

module rese_fifo
    import rese_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire row_item_t push_item,
    output logic           push_ready,
    input  wire logic      pop,
    output row_item_t      pop_item,
    output logic           pop_valid
);

    localparam int DEPTH = 2;

    row_item_t  slot_reg [DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign push_ready = count_reg != 2'(DEPTH);
    assign pop_valid  = count_reg != 2'd0;
    assign pop_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/rese_back.sv @@
// Sort engine: fill the row store, run the exchange sort, stream the sorted row out.
`timescale 1ns / 1ps
`default_nettype none

module rese_back
    import rese_pkg::*;
#(
    parameter int MAX_SIZE = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           clear,
    input  wire logic [$clog2(MAX_SIZE+1)-1:0]  size_n,
    input  wire logic                           q_valid,
    input  wire row_item_t                      q_item,
    output logic                                q_pop,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [VAL_W-1:0]             sorted_value,
    output logic [TALLY_W-1:0]                  swap_total,
    output logic                                row_end,
    output logic                                matrix_end
);

    localparam int CNT_W = $clog2(MAX_SIZE + 1);
    localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

    localparam logic [2:0] S_FILL = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_AGET = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;
    localparam logic [2:0] S_ERD  = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    // Row store: one write port, one registered read port
    logic signed [VAL_W-1:0] store_mem [MAX_SIZE];
    logic signed [VAL_W-1:0] rdata_reg;
    logic                    we;
    logic [IDX_W-1:0]        waddr;
    logic signed [VAL_W-1:0] wdata;
    logic [IDX_W-1:0]        raddr;

    logic [2:0]              state_reg, state_next;
    logic [IDX_W-1:0]        fill_reg, fill_next;
    logic [IDX_W-1:0]        j_reg, j_next;
    logic [IDX_W-1:0]        k_reg, k_next;
    logic signed [VAL_W-1:0] a_reg, a_next;
    logic                    mlast_reg, mlast_next;
    logic [TALLY_W-1:0]      tally_reg, tally_next;

    logic                    out_valid_reg, out_valid_next;
    logic signed [VAL_W-1:0] value_reg, value_next;
    logic [TALLY_W-1:0]      total_reg, total_next;
    logic                    row_end_reg, row_end_next;
    logic                    matrix_end_reg, matrix_end_next;

    logic k_last;
    logic j_last;
    logic swap;
    logic load;

    assign k_last = (CNT_W'(k_reg) + CNT_W'(1)) == size_n;
    assign j_last = (CNT_W'(j_reg) + CNT_W'(1)) == size_n;
    assign swap   = (state_reg == S_CMP) && (k_reg != j_reg) && (a_reg < rdata_reg);
    assign load   = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    assign out_valid    = out_valid_reg;
    assign sorted_value = value_reg;
    assign swap_total   = total_reg;
    assign row_end      = row_end_reg;
    assign matrix_end   = matrix_end_reg;

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        a_next          = a_reg;
        mlast_next      = mlast_reg;
        tally_next      = tally_reg;
        value_next      = value_reg;
        total_next      = total_reg;
        row_end_next    = row_end_reg;
        matrix_end_next = matrix_end_reg;
        we              = 1'b0;
        waddr           = fill_reg;
        wdata           = q_item.value;
        raddr           = '0;
        q_pop           = 1'b0;

        case (state_reg)
            S_FILL:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    we    = 1'b1;
                    if (q_item.row_last)
                    begin
                        fill_next  = '0;
                        mlast_next = q_item.matrix_last;
                        j_next     = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        fill_next = IDX_W'(fill_reg + IDX_W'(1));
                    end
                end
            end
            S_LOAD:
            begin
                raddr      = j_reg;
                state_next = S_AGET;
            end
            S_AGET:
            begin
                a_next     = rdata_reg;
                k_next     = '0;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // a_reg holds entry j; swap moves it out to entry k
                if (swap)
                begin
                    we     = 1'b1;
                    waddr  = k_reg;
                    wdata  = a_reg;
                    a_next = rdata_reg;
                    if (tally_reg != TALLY_MAX)
                    begin
                        tally_next = tally_reg + TALLY_W'(1);
                    end
                end
                if (k_last)
                begin
                    raddr      = k_reg;
                    state_next = S_WB;
                end
                else
                begin
                    raddr  = IDX_W'(k_reg + IDX_W'(1));
                    k_next = IDX_W'(k_reg + IDX_W'(1));
                end
            end
            S_WB:
            begin
                we    = 1'b1;
                waddr = j_reg;
                wdata = a_reg;
                if (j_last)
                begin
                    state_next = S_ERD;
                end
                else
                begin
                    raddr      = IDX_W'(j_reg + IDX_W'(1));
                    j_next     = IDX_W'(j_reg + IDX_W'(1));
                    state_next = S_AGET;
                end
            end
            S_ERD:
            begin
                k_next     = '0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                raddr = k_reg;
                if (load)
                begin
                    value_next      = rdata_reg;
                    total_next      = tally_reg;
                    row_end_next    = k_last;
                    matrix_end_next = k_last && mlast_reg;
                    if (k_last)
                    begin
                        state_next = S_FILL;
                        if (mlast_reg)
                        begin
                            tally_next = '0;
                        end
                    end
                    else
                    begin
                        raddr  = IDX_W'(k_reg + IDX_W'(1));
                        k_next = IDX_W'(k_reg + IDX_W'(1));
                    end
                end
            end
            default:
            begin
                state_next = S_FILL;
            end
        endcase

        if (clear)
        begin
            fill_next  = '0;
            tally_next = '0;
        end

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
        rdata_reg <= store_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        j_reg          <= j_next;
        k_reg          <= k_next;
        mlast_reg      <= mlast_next;
        value_reg      <= value_next;
        total_reg      <= total_next;
        row_end_reg    <= row_end_next;
        matrix_end_reg <= matrix_end_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            fill_reg      <= '0;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            tally_reg     <= tally_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_tally_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (tally_reg >= $past(tally_reg)) || (tally_reg == '0))
        else $error("swap tally went down without a clear");

    a_k_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP || state_reg == S_EMIT) |-> (CNT_W'(k_reg) < size_n))
        else $error("inner index beyond row length");

    a_j_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB) |-> (CNT_W'(j_reg) < size_n))
        else $error("outer index beyond row length");

    a_matrix_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && matrix_end_reg) |-> row_end_reg)
        else $error("matrix end flagged off a row end");
`endif

endmodule

`default_nettype wire

@@ rtl/core/row_exchange_sort_swap_count.sv @@
// Top level of the row exchange sorter with swap counting.
`timescale 1ns / 1ps
`default_nettype none

// Row exchange sorter. Feed a square matrix of signed 16-bit values in
// row-major order on element_value. Each completed row is sorted ascending
// with the plain double-loop exchange sort and comes back out one item per
// element on sorted_value, together with the matrix's running swap count
// (swap_total, saturating at 65535), row_end on the row's last element and
// matrix_end on the last element of the matrix. The matrix size comes from the
// matrix_size register at byte address 0 (0 acts as 1, values above MAX_SIZE
// act as MAX_SIZE); writing it starts a new matrix. For each row the sort
// engine takes the row in, sorts it and then emits it, and it takes no
// new item while it sorts or emits. The row store has a single read port:
// each compare step reads one entry, and each outer pass also fetches and
// writes back the held entry. A two-entry queue lets the input side accept
// up to two items while the engine is busy, and the output register holds
// a result until it is taken, so the engine can take in and sort the next
// row while the row's last result waits.
module row_exchange_sort_swap_count
    import rese_pkg::*;
#(
    parameter int MAX_SIZE = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [APB_ADDR_W-1:0]   paddr,
    input  wire logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic signed [VAL_W-1:0] element_value,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic signed [VAL_W-1:0]      sorted_value,
    output logic [TALLY_W-1:0]           swap_total,
    output logic                         row_end,
    output logic                         matrix_end
);

    localparam int CNT_W = $clog2(MAX_SIZE + 1);
    localparam int SZ_W  = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

    logic [SIZE_W-1:0] size_reg, size_next;
    logic [SZ_W-1:0]   size_ext;
    logic [CNT_W-1:0]  size_n;
    logic              cfg_write;
    logic              cfg_clear;

    row_item_t q_in_item;
    row_item_t q_out_item;
    logic      q_push;
    logic      q_ready;
    logic      q_valid;
    logic      q_pop;

    // Config port: zero wait states, write lands on the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_clear = cfg_write && (paddr[2] == REG_MATRIX_SIZE);

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_MATRIX_SIZE)
        begin
            prdata = APB_DATA_W'(size_reg);
        end
    end

    always_comb
    begin
        size_next = size_reg;
        if (cfg_clear)
        begin
            size_next = pwdata[SIZE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else
        begin
            size_reg <= size_next;
        end
    end

    // Clamp the programmed size into 1..MAX_SIZE
    assign size_ext = SZ_W'(size_reg);

    always_comb
    begin
        if (size_ext == '0)
        begin
            size_n = CNT_W'(1);
        end
        else if (size_ext > SZ_W'(MAX_SIZE))
        begin
            size_n = CNT_W'(MAX_SIZE);
        end
        else
        begin
            size_n = CNT_W'(size_ext);
        end
    end

    // Front: take items, tag row and matrix boundaries
    rese_front #(
        .MAX_SIZE (MAX_SIZE)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .clear         (cfg_clear),
        .size_n        (size_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .element_value (element_value),
        .q_push        (q_push),
        .q_item        (q_in_item),
        .q_ready       (q_ready)
    );

    // Decouple intake from the sort engine
    rese_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_in_item),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_item   (q_out_item),
        .pop_valid  (q_valid)
    );

    // Back: buffer the row, sort, emit
    rese_back #(
        .MAX_SIZE (MAX_SIZE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .clear        (cfg_clear),
        .size_n       (size_n),
        .q_valid      (q_valid),
        .q_item       (q_out_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sorted_value (sorted_value),
        .swap_total   (swap_total),
        .row_end      (row_end),
        .matrix_end   (matrix_end)
    );

endmodule

`default_nettype wire
